// File: hdl/sgm_pkg.sv
`timescale 1ns / 1ps

package sgm_pkg;

    localparam int SGM_MAX_WIDTH = 2048;
    localparam int SGM_MAX_HEIGHT = 4096;
    localparam int SGM_PIX_W = 8;
    localparam int SGM_FW_W = 12;
    localparam int SGM_FH_W = 13;
    localparam int SGM_CNT_W = 12;
    localparam int SGM_CFG_W = 13;
    localparam int SGM_WIDTH_RESET = 640;
    localparam int SGM_HEIGHT_RESET = 480;
    localparam int SGM_DIM_MIN = 3;
    localparam logic [7:0] SGM_MAG_MAX = 8'd255;

    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } t_tag;

    typedef logic [2:0][2:0][7:0] t_win;

    typedef struct packed {
        logic [9:0] rem;
        logic [7:0] root;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(input t_sqrt cur, input logic [1:0] pair);
        logic [11:0] acc;
        logic [11:0] trial;
        t_sqrt nxt;
        acc = {cur.rem, pair};
        trial = {2'b00, cur.root, 2'b01};
        if (acc >= trial) begin
            nxt.rem = 10'(acc - trial);
            nxt.root = {cur.root[6:0], 1'b1};
        end else begin
            nxt.rem = acc[9:0];
            nxt.root = {cur.root[6:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// File: hdl/sgm_pixel_if.sv
`timescale 1ns / 1ps

interface sgm_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

// File: hdl/sgm_result_if.sv
`timescale 1ns / 1ps

interface sgm_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] magnitude;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output magnitude, output row_end, output frame_end,
                    input ready);
    modport sink (input valid, input magnitude, input row_end, input frame_end,
                  output ready);
endinterface

// File: hdl/sgm_line_window.sv
`timescale 1ns / 1ps

module sgm_line_window import sgm_pkg::*; #(
    parameter int MAX_WIDTH = SGM_MAX_WIDTH,
    parameter int AW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_clear,
    input  logic          i_acc,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_pixel,
    input  t_tag          i_tag,
    output logic          o_valid,
    output t_tag          o_tag,
    output t_win          o_win
);

    logic [15:0]   mem [MAX_WIDTH];
    logic [15:0]   r_rd;
    logic          r_v1;
    logic [AW-1:0] r_addr1;
    logic [7:0]    r_px1;
    t_tag          r_tag1;
    logic          r_v2;
    t_tag          r_tag2;
    t_win          r_win;
    t_win          n_win;

    // Each entry holds the pixel two rows up in the high byte and one row up in the low byte.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd <= mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && r_v1) begin
            mem[r_addr1] <= {r_rd[7:0], r_px1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_addr1 <= i_addr;
            r_px1 <= i_pixel;
            r_tag1 <= i_tag;
        end
        if (i_en) begin
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = r_rd[15:8];
        n_win[1][2] = r_rd[7:0];
        n_win[2][2] = r_px1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_win <= '0;
        end else if (i_en && r_v1) begin
            r_win <= n_win;
        end
    end

    assign o_valid = r_v2 && r_tag2.produce;
    assign o_tag = r_tag2;
    assign o_win = r_win;

endmodule

// File: hdl/sgm_mag.sv
`timescale 1ns / 1ps

module sgm_mag import sgm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_tag       i_tag,
    input  t_win       i_win,
    output logic       o_valid,
    output t_tag       o_tag,
    output logic [7:0] o_magnitude
);

    logic [9:0]         pos_x;
    logic [9:0]         neg_x;
    logic [9:0]         pos_y;
    logic [9:0]         neg_y;
    logic signed [10:0] n_gx;
    logic signed [10:0] n_gy;
    logic signed [21:0] sq_x;
    logic signed [21:0] sq_y;
    logic [20:0]        sum;
    t_sqrt              hi_steps [5];
    t_sqrt              lo_steps [5];

    logic               r_v3;
    logic               r_v4;
    logic               r_v5;
    logic               r_v6;
    logic               r_out_valid;
    t_tag               r_tag3;
    t_tag               r_tag4;
    t_tag               r_tag5;
    t_tag               r_tag6;
    t_tag               r_tag_out;
    logic signed [10:0] r_gx;
    logic signed [10:0] r_gy;
    logic [19:0]        r_sqx;
    logic [19:0]        r_sqy;
    logic [15:0]        r_sum;
    logic               r_sat5;
    logic               r_sat6;
    logic [7:0]         r_low6;
    t_sqrt              r_part6;
    logic [7:0]         r_mag;

    always_comb begin
        pos_x = {2'b00, i_win[0][2]} + {1'b0, i_win[1][2], 1'b0} + {2'b00, i_win[2][2]};
        neg_x = {2'b00, i_win[0][0]} + {1'b0, i_win[1][0], 1'b0} + {2'b00, i_win[2][0]};
        pos_y = {2'b00, i_win[0][0]} + {1'b0, i_win[0][1], 1'b0} + {2'b00, i_win[0][2]};
        neg_y = {2'b00, i_win[2][0]} + {1'b0, i_win[2][1], 1'b0} + {2'b00, i_win[2][2]};
        n_gx = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
        n_gy = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
    end

    assign sq_x = r_gx * r_gx;
    assign sq_y = r_gy * r_gy;
    assign sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    // The root is built two input bits at a time, four steps per stage.
    always_comb begin
        hi_steps[0] = '0;
        for (int i = 0; i < 4; i++) begin
            hi_steps[i+1] = sqrt_step(hi_steps[i], r_sum[15-2*i -: 2]);
        end
        lo_steps[0] = r_part6;
        for (int i = 0; i < 4; i++) begin
            lo_steps[i+1] = sqrt_step(lo_steps[i], r_low6[7-2*i -: 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gx <= n_gx;
            r_gy <= n_gy;
            r_tag3 <= i_tag;
            r_sqx <= sq_x[19:0];
            r_sqy <= sq_y[19:0];
            r_tag4 <= r_tag3;
            r_sum <= sum[15:0];
            r_sat5 <= (sum[20:16] != 5'd0);
            r_tag5 <= r_tag4;
            r_part6 <= hi_steps[4];
            r_low6 <= r_sum[7:0];
            r_sat6 <= r_sat5;
            r_tag6 <= r_tag5;
            r_mag <= r_sat6 ? SGM_MAG_MAX : lo_steps[4].root;
            r_tag_out <= r_tag6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_out_valid <= r_v6;
        end
    end

    assign o_valid = r_out_valid;
    assign o_tag = r_tag_out;
    assign o_magnitude = r_mag;

endmodule

// File: hdl/sobel_gradient_magnitude.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                          Item
// i_pix     in   pixel[7:0]                       one grey pixel, raster order
// o_res     out  magnitude[7:0], row_end, frame_end  one interior gradient magnitude
//
// One pixel is taken per cycle while the stages advance; a result is presented once the
// pixel that completes it has passed the window register and the sgm_mag registers.
// The rate is set by the single read and single write per cycle of the line store memory.
// All stages advance together whenever the output register is empty or being taken.
// Reset and every register write restart the frame; the line store is not cleared,
// since the first two rows of each frame fill it before any result reads it.

module sobel_gradient_magnitude import sgm_pkg::*; #(
    parameter int MAX_WIDTH = SGM_MAX_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgm_pixel_if.sink            i_pix,
    sgm_result_if.source         o_res,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [SGM_CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WIDTH_HI = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
    localparam int WIDTH_RST = (SGM_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : SGM_WIDTH_RESET;

    logic                 en;
    logic                 acc;
    logic                 last_col;
    logic                 last_row;
    t_tag                 in_tag;
    logic [SGM_FW_W-1:0]  cfg_width;
    logic [SGM_FH_W-1:0]  cfg_height;
    logic                 win_valid;
    t_tag                 win_tag;
    t_win                 win;
    logic                 mag_valid;
    t_tag                 mag_tag;
    logic [7:0]           mag;

    logic [SGM_FW_W-1:0]  r_frame_width;
    logic [SGM_FH_W-1:0]  r_frame_height;
    logic [SGM_CNT_W-1:0] r_col;
    logic [SGM_CNT_W-1:0] r_row;
    logic [SGM_CNT_W-1:0] n_col;
    logic [SGM_CNT_W-1:0] n_row;

    assign en = !mag_valid || o_res.ready;
    assign acc = i_pix.valid && en;
    assign i_pix.ready = en;

    assign last_col = (r_col == r_frame_width - 12'd1);
    assign last_row = ({1'b0, r_row} == r_frame_height - 13'd1);

    always_comb begin
        in_tag.produce = (r_row >= 12'd2) && (r_col >= 12'd2);
        in_tag.row_end = last_col;
        in_tag.frame_end = last_col && last_row;
    end

    always_comb begin
        cfg_width = i_cfg_data[SGM_FW_W-1:0];
        if (cfg_width < SGM_FW_W'(SGM_DIM_MIN)) begin
            cfg_width = SGM_FW_W'(SGM_DIM_MIN);
        end else if (cfg_width > SGM_FW_W'(WIDTH_HI)) begin
            cfg_width = SGM_FW_W'(WIDTH_HI);
        end
        cfg_height = i_cfg_data;
        if (cfg_height < SGM_FH_W'(SGM_DIM_MIN)) begin
            cfg_height = SGM_FH_W'(SGM_DIM_MIN);
        end else if (cfg_height > SGM_FH_W'(SGM_MAX_HEIGHT)) begin
            cfg_height = SGM_FH_W'(SGM_MAX_HEIGHT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= SGM_FW_W'(WIDTH_RST);
            r_frame_height <= SGM_FH_W'(SGM_HEIGHT_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= cfg_width;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= cfg_height;
                end
                default: begin
                    r_frame_width <= r_frame_width;
                end
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 12'd1;
            end else begin
                n_col = r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    sgm_line_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_clear (i_cfg_we),
        .i_acc   (acc),
        .i_addr  (AW'(r_col)),
        .i_pixel (i_pix.pixel),
        .i_tag   (in_tag),
        .o_valid (win_valid),
        .o_tag   (win_tag),
        .o_win   (win)
    );

    sgm_mag u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (win_valid),
        .i_tag       (win_tag),
        .i_win       (win),
        .o_valid     (mag_valid),
        .o_tag       (mag_tag),
        .o_magnitude (mag)
    );

    assign o_res.valid = mag_valid;
    assign o_res.magnitude = mag;
    assign o_res.row_end = mag_tag.row_end;
    assign o_res.frame_end = mag_tag.frame_end;

endmodule

// File: tb/sgm_magnitude_checker.sv
`timescale 1ns / 1ps

module sgm_magnitude_checker import sgm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgm_pixel_if                 i_pix,
    sgm_result_if                i_res,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [SGM_CFG_W-1:0] i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic [7:0] magnitude;
        logic       row_end;
        logic       frame_end;
    } t_grad_item;

    t_grad_item  due_grads[$];
    logic [7:0]  older_line [SGM_MAX_WIDTH];
    logic [7:0]  newer_line [SGM_MAX_WIDTH];
    logic [7:0]  win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned frame_w;
    int unsigned frame_h;
    int          mismatches = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < SGM_DIM_MIN) return SGM_DIM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] root_sat(input int unsigned sum_sq);
        int unsigned r;
        int unsigned t;
        if (sum_sq >= 65536) return SGM_MAG_MAX;
        r = 0;
        for (int b = 7; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= sum_sq) r = t;
        end
        return 8'(r);
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
    endtask

    task automatic sobel_step(input logic [7:0] px);
        logic [7:0] up;
        logic [7:0] mid;
        int         gx;
        int         gy;
        t_grad_item g;
        up = older_line[col_pos];
        mid = newer_line[col_pos];
        older_line[col_pos] = mid;
        newer_line[col_pos] = px;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = px;
        if (row_pos >= 2 && col_pos >= 2) begin
            gx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
               - int'(win[0][0]) - 2 * int'(win[1][0]) - int'(win[2][0]);
            gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
               - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
            g.magnitude = root_sat(gx * gx + gy * gy);
            g.row_end = (col_pos + 1 >= frame_w);
            g.frame_end = g.row_end && (row_pos + 1 >= frame_h);
            due_grads.insert(due_grads.size(), g);
        end
        col_pos++;
        if (col_pos >= frame_w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= frame_h) row_pos = 0;
        end
    endtask

    task automatic check_result();
        t_grad_item got;
        t_grad_item want;
        got = {i_res.magnitude, i_res.row_end, i_res.frame_end};
        if (due_grads.size() == 0) begin
            $display("%0t: unexpected item, expected none, got %0d/%b/%b",
                     $time, got.magnitude, got.row_end, got.frame_end);
            mismatches++;
        end else begin
            want = due_grads.pop_front();
            if (got.magnitude !== want.magnitude || got.row_end !== want.row_end ||
                got.frame_end !== want.frame_end) begin
                $display("%0t: mismatch, expected %0d/%b/%b, got %0d/%b/%b", $time,
                         want.magnitude, want.row_end, want.frame_end,
                         got.magnitude, got.row_end, got.frame_end);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SGM_MAX_WIDTH; i++) begin
                older_line[i] = '0;
                newer_line[i] = '0;
            end
            frame_w = SGM_WIDTH_RESET;
            frame_h = SGM_HEIGHT_RESET;
            restart_frame();
            due_grads.delete();
        end else begin
            if (i_res.valid && i_res.ready) check_result();
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH)
                    frame_w = clamp_dim(i_cfg_data[SGM_FW_W-1:0], SGM_MAX_WIDTH);
                else
                    frame_h = clamp_dim(i_cfg_data[SGM_FH_W-1:0], SGM_MAX_HEIGHT);
                restart_frame();
            end
            if (i_pix.valid && i_pix.ready) sobel_step(i_pix.pixel);
        end
        o_pending <= due_grads.size();
        o_errors <= mismatches;
    end

endmodule

// File: tb/sobel_gradient_magnitude_tb.sv
`timescale 1ns / 1ps

module sobel_gradient_magnitude_tb;
    import sgm_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 560;

    typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_BINARY, PIX_MIXED} t_pix_style;

    localparam logic [7:0] STEP_EDGE [9] = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255,
                                             8'd0, 8'd0, 8'd255};
    localparam logic [7:0] RAMP [9] = '{8'd0, 8'd3, 8'd6, 8'd3, 8'd6, 8'd9,
                                        8'd6, 8'd9, 8'd12};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [SGM_CFG_W-1:0] cfg_data;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    int                   src_calm = 0;
    int                   sink_calm = 0;
    logic [7:0]           last_px = 8'd128;

    sgm_pixel_if  pix_ch ();
    sgm_result_if res_ch ();

    sobel_gradient_magnitude dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sgm_magnitude_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .i_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("sobel_gradient_magnitude test failed");
            $finish;
        end
    end

    function automatic logic [7:0] next_pixel(input t_pix_style style);
        t_pix_style pick;
        int         v;
        pick = style;
        if (pick == PIX_MIXED) pick = t_pix_style'($urandom_range(0, 2));
        case (pick)
            PIX_SMOOTH: begin
                v = int'(last_px) + int'($urandom_range(0, 16)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            PIX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
            default: v = $urandom_range(0, 255);
        endcase
        last_px = 8'(v);
        return 8'(v);
    endfunction

    task automatic send_pixel(input logic [7:0] px);
        int gap;
        if (src_calm > 0) begin
            src_calm--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0) src_calm = $urandom_range(16, 96);
        end
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        do @(posedge i_clk); while (!(pix_ch.valid && pix_ch.ready));
    endtask

    task automatic write_reg(input logic idx, input int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= SGM_CFG_W'(value);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every predicted item has arrived, then lets the pipeline empty.
    task automatic settle();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned n,
                             input t_pix_style style);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        for (int unsigned k = 0; k < n; k++) begin
            send_pixel(next_pixel(style));
            if ($urandom_range(0, 199) == 0) settle();
        end
        settle();
    endtask

    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_calm > 0) begin
                sink_calm--;
                stall = 0;
            end else begin
                stall = $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0) sink_calm = $urandom_range(16, 96);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned sent;
        i_rst_n <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out-of-range sizes clamp to the minimum; a partial frame is then cut off
        // by a register write, and the width write carries a bit above its field.
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 1);
        repeat (4) send_pixel(8'd255);
        settle();
        write_reg(CFG_FRAME_WIDTH, 32'h1003);
        write_reg(CFG_FRAME_HEIGHT, 3);
        for (int i = 0; i < 9; i++) send_pixel(STEP_EDGE[i]);
        for (int i = 0; i < 9; i++) send_pixel(RAMP[i]);
        settle();

        run_phase(5, 8191, 80, PIX_MIXED);
        run_phase(3, SGM_MAX_HEIGHT, 60, PIX_SMOOTH);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w = $urandom_range(3, 16);
            h = $urandom_range(3, 6);
            n = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
            run_phase(w, h, n, t_pix_style'($urandom_range(0, 3)));
            sent += n;
        end

        run_phase(4095, 3, 150, PIX_MIXED);

        if (errors == 0 && pending == 0) begin
            $display("sobel_gradient_magnitude test passed");
        end else begin
            $display("sobel_gradient_magnitude test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/sgm_pkg.sv
hdl/sgm_pixel_if.sv
hdl/sgm_result_if.sv
hdl/sgm_line_window.sv
hdl/sgm_mag.sv
hdl/sobel_gradient_magnitude.sv
tb/sgm_magnitude_checker.sv
tb/sobel_gradient_magnitude_tb.sv
